// ===== sv/block_then_binary_search_macros.svh =====
// Assertion macros shared by the block-then-binary search RTL.
// Each macro expands to one labelled concurrent assertion on clk_i, disabled in reset.
`ifndef BLOCK_THEN_BINARY_SEARCH_MACROS_SVH
`define BLOCK_THEN_BINARY_SEARCH_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BTS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("block_then_binary_search: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define BTS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("block_then_binary_search: next-cycle check failed");

`endif

// ===== sv/bts_pkg.sv =====
// Package for the block-then-binary search: widths, codes and the
// command and status structs between the controller and the datapath. No dependencies.
`timescale 1ns / 1ps

package bts_pkg;

  localparam int unsigned MaxElements = 1024;
  localparam int unsigned AddrW       = $clog2(MaxElements);
  localparam int unsigned LenW        = 11;
  localparam int unsigned SumW        = LenW + 1;
  localparam int unsigned DataW       = 32;
  localparam int unsigned PosW        = 10;
  localparam int unsigned CfgIdxW     = 1;

  localparam logic [LenW-1:0] LenReset   = LenW'(1024);
  localparam logic [LenW-1:0] BlockReset = LenW'(32);

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  localparam logic [CfgIdxW-1:0] CFG_ARRAY_LENGTH = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CFG_BLOCK_SIZE   = CfgIdxW'(1);

  typedef logic signed [DataW-1:0] data_t;

  typedef enum logic [1:0] {
    ADDR_CUR,
    ADDR_RIGHT,
    ADDR_NEXT,
    ADDR_MID
  } addr_sel_e;

  typedef struct packed {
    logic      mem_we;
    logic      search_init;
    addr_sel_e addr_sel;
    logic      cap_start;
    logic      adv_c;
    logic      bs_init;
    logic      bs_step;
    logic      res_set;
    logic      res_found;
    logic      out_load;
  } cmd_t;

  typedef struct packed {
    logic n_zero;
    logic hit;
    logic last;
    logic eq;
    logic fail;
  } status_t;

endpackage

// ===== sv/bts_if.sv =====
// Channel interfaces of the block-then-binary search: input items, result
// items and configuration writes. Depends on bts_pkg.
`timescale 1ns / 1ps

interface bts_in_if;
  import bts_pkg::*;
  logic              valid;
  logic              ready;
  logic              opcode;
  logic [AddrW-1:0]  index;
  data_t             value;
  modport source (output valid, output opcode, output index, output value, input ready);
  modport sink   (input valid, input opcode, input index, input value, output ready);
endinterface

interface bts_out_if;
  import bts_pkg::*;
  logic            valid;
  logic            ready;
  logic            found;
  logic [PosW-1:0] position;
  modport source (output valid, output found, output position, input ready);
  modport sink   (input valid, input found, input position, output ready);
endinterface

interface bts_cfg_if;
  import bts_pkg::*;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [LenW-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/block_then_binary_search.sv =====
// Block-then-binary search over a loaded ascending array (top level).
// Channels: in_i takes items (opcode load: write value at index, no result;
// opcode search: look for value), out_o gives one result item (found,
// position) per search, cfg_i writes array_length (index 0) and block_size
// (index 1) and is always ready. All channels move an item when valid and
// ready are both high.
// A load writes its element as it is accepted. A search runs a set-up, then
// a read and check of each block checkpoint scanned and a read and compare per
// bisection step, and then hands over the result.
// The element memory has one read port, read once per cycle; that sets the rate.
// One search is in flight at a time; the next item is accepted as soon as the
// result sits in the output register, even while the receiver stalls. A
// second finished result waits in its result registers until the output frees.
// Reset sets length 1024 and block size 32; memory contents are undefined
// until loaded. Depends on bts_pkg, bts_if, bts_ctrl and bts_dp.
`timescale 1ns / 1ps

module block_then_binary_search
  import bts_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  bts_in_if.sink    in_i,
  bts_out_if.source out_o,
  bts_cfg_if.sink   cfg_i
);

  cmd_t    cmd;
  status_t status;

  bts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_opcode_i (in_i.opcode),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  bts_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .index_i     (in_i.index),
    .value_i     (in_i.value),
    .cfg_valid_i (cfg_i.valid),
    .cfg_index_i (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .cfg_ready_o (cfg_i.ready),
    .found_o     (out_o.found),
    .position_o  (out_o.position)
  );

endmodule

// ===== sv/bts_dp.sv =====
// Datapath of the block-then-binary search: element memory, configuration
// registers, checkpoint and bisection registers, result registers. Depends on bts_pkg.
`timescale 1ns / 1ps

module bts_dp
  import bts_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output status_t            status_o,
  input  logic [AddrW-1:0]   index_i,
  input  data_t              value_i,
  input  logic               cfg_valid_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [LenW-1:0]    cfg_data_i,
  output logic               cfg_ready_o,
  output logic               found_o,
  output logic [PosW-1:0]    position_o
);

  data_t            mem_q [MaxElements];
  data_t            rdata_q;
  logic [AddrW-1:0] rd_addr;

  logic [LenW-1:0]  length_q, block_q;
  logic [LenW-1:0]  n_q, b_q;
  data_t            key_q;
  logic [AddrW-1:0] c_q, lo_q, hi_q;
  logic             start_le_q;
  logic             found_q;
  logic [AddrW-1:0] pos_q;
  logic             out_found_q;
  logic [AddrW-1:0] out_pos_q;

  logic [SumW-1:0]  next_sum;
  logic [LenW-1:0]  last_idx;
  logic [AddrW-1:0] right;
  logic [AddrW:0]   mid_sum;
  logic [AddrW-1:0] mid;
  logic             gt;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      length_q <= LenReset;
      block_q  <= BlockReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_ARRAY_LENGTH: length_q <= cfg_data_i;
        CFG_BLOCK_SIZE:   block_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The block's right end is the next checkpoint, clamped to the last element.
  assign next_sum = {{(SumW-AddrW){1'b0}}, c_q} + {1'b0, b_q};
  assign last_idx = n_q - LenW'(1);
  assign right    = (next_sum > {1'b0, last_idx}) ? last_idx[AddrW-1:0]
                                                   : next_sum[AddrW-1:0];
  assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid      = mid_sum[AddrW:1];
  assign gt       = rdata_q > key_q;

  always_comb begin
    case (cmd_i.addr_sel)
      ADDR_CUR:   rd_addr = c_q;
      ADDR_RIGHT: rd_addr = right;
      ADDR_NEXT:  rd_addr = next_sum[AddrW-1:0];
      ADDR_MID:   rd_addr = mid;
      default:    rd_addr = c_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_we) begin
      mem_q[index_i] <= value_i;
    end
    rdata_q <= mem_q[rd_addr];
  end

  assign status_o.n_zero = (n_q == '0);
  assign status_o.hit    = start_le_q && (rdata_q >= key_q);
  assign status_o.last   = (next_sum >= {1'b0, n_q});
  assign status_o.eq     = (rdata_q == key_q);
  // The bisection runs out when it would step past either end of the range.
  assign status_o.fail   = (gt && (mid == lo_q)) || (!gt && (rdata_q != key_q) && (mid == hi_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.search_init) begin
      n_q   <= (length_q > LenW'(MaxElements)) ? LenW'(MaxElements) : length_q;
      b_q   <= (block_q == '0) ? LenW'(1) : block_q;
      c_q   <= '0;
      key_q <= value_i;
    end else if (cmd_i.adv_c) begin
      c_q <= next_sum[AddrW-1:0];
    end
    if (cmd_i.cap_start) begin
      start_le_q <= (rdata_q <= key_q);
    end
    if (cmd_i.bs_init) begin
      lo_q <= c_q;
      hi_q <= right;
    end else if (cmd_i.bs_step) begin
      if (gt) begin
        hi_q <= mid - AddrW'(1);
      end else begin
        lo_q <= mid + AddrW'(1);
      end
    end
    if (cmd_i.res_set) begin
      found_q <= cmd_i.res_found;
      pos_q   <= cmd_i.res_found ? mid : '0;
    end
    if (cmd_i.out_load) begin
      out_found_q <= found_q;
      out_pos_q   <= pos_q;
    end
  end

  assign found_o    = out_found_q;
  assign position_o = PosW'(out_pos_q);

endmodule

// ===== sv/bts_ctrl.sv =====
// Controller of the block-then-binary search: sequences load writes,
// checkpoint scan, bisection and result hand-off. Depends on bts_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "block_then_binary_search_macros.svh"

module bts_ctrl
  import bts_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    in_opcode_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CK_C  = 3'd1;
  localparam logic [2:0] S_CK_R  = 3'd2;
  localparam logic [2:0] S_CK_EV = 3'd3;
  localparam logic [2:0] S_BS_RD = 3'd4;
  localparam logic [2:0] S_BS_EV = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       in_acc, out_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o       = '0;
    cmd_o.addr_sel = ADDR_CUR;
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (in_opcode_i == OP_SEARCH) begin
            cmd_o.search_init = 1'b1;
            state_d = S_CK_C;
          end else begin
            cmd_o.mem_we = 1'b1;
          end
        end
      end
      S_CK_C: begin
        if (status_i.n_zero) begin
          cmd_o.res_set = 1'b1;
          state_d = S_DONE;
        end else begin
          cmd_o.addr_sel = ADDR_CUR;
          state_d = S_CK_R;
        end
      end
      S_CK_R: begin
        // Read data now holds the block start.
        cmd_o.addr_sel  = ADDR_RIGHT;
        cmd_o.cap_start = 1'b1;
        state_d = S_CK_EV;
      end
      S_CK_EV: begin
        if (status_i.hit) begin
          cmd_o.bs_init = 1'b1;
          state_d = S_BS_RD;
        end else if (status_i.last) begin
          cmd_o.res_set = 1'b1;
          state_d = S_DONE;
        end else begin
          // Fetch the next block start while stepping the checkpoint.
          cmd_o.adv_c    = 1'b1;
          cmd_o.addr_sel = ADDR_NEXT;
          state_d = S_CK_R;
        end
      end
      S_BS_RD: begin
        cmd_o.addr_sel = ADDR_MID;
        state_d = S_BS_EV;
      end
      S_BS_EV: begin
        if (status_i.eq) begin
          cmd_o.res_set   = 1'b1;
          cmd_o.res_found = 1'b1;
          state_d = S_DONE;
        end else if (status_i.fail) begin
          cmd_o.res_set = 1'b1;
          state_d = S_DONE;
        end else begin
          cmd_o.bs_step = 1'b1;
          state_d = S_BS_RD;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  `BTS_ASSERT_NEXT(a_search_blocks_input, in_acc && (in_opcode_i == OP_SEARCH), !in_ready_o)
  `BTS_ASSERT_SAME(a_load_only_when_free, cmd_o.out_load, out_free)
  `BTS_ASSERT_NEXT(a_done_gives_result, (state_q == S_DONE) && out_free, out_valid_o)
  `BTS_ASSERT_SAME(a_write_only_on_load, cmd_o.mem_we, in_acc && (in_opcode_i == OP_LOAD))

endmodule
